[hw/rtl/set_assoc_lru_cache_model_assert.svh]
// Assertion macros for the LRU cache model top level.
// Expects clk and rst in the scope of use.
`ifndef SET_ASSOC_LRU_CACHE_MODEL_ASSERT_SVH
`define SET_ASSOC_LRU_CACHE_MODEL_ASSERT_SVH

// same-cycle implication
`define SALC_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("salc assertion failed");

// next-cycle implication
`define SALC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("salc assertion failed");

`endif

[hw/rtl/salc_pkg.sv]
// Shared types and codes of the LRU cache model.
// No dependencies.
`timescale 1ns / 1ps
package salc_pkg;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_STORE = 2'd1;
  localparam logic [1:0] MODE_FETCH = 2'd2;
  localparam logic [1:0] MODE_FLUSH = 2'd3;

  localparam logic [3:0] REG_SPLIT_MODE     = 4'd0;
  localparam logic [3:0] REG_UNIFIED_SETS   = 4'd1;
  localparam logic [3:0] REG_INST_SETS      = 4'd2;
  localparam logic [3:0] REG_DATA_SETS      = 4'd3;
  localparam logic [3:0] REG_BLOCK_OFFSET   = 4'd4;
  localparam logic [3:0] REG_WAYS           = 4'd5;
  localparam logic [3:0] REG_WRITE_BACK     = 4'd6;
  localparam logic [3:0] REG_WRITE_ALLOCATE = 4'd7;

  localparam logic [1:0] RD_IN    = 2'd0;
  localparam logic [1:0] RD_HOLD  = 2'd1;
  localparam logic [1:0] RD_SWEEP = 2'd2;

  localparam int TAG_W = 30;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] address;
  } in_t;

  typedef struct packed {
    logic        hit;
    logic        missed;
    logic        replaced;
    logic [5:0]  fetch_words;
    logic [5:0]  copyback_words;
    logic [19:0] flush_words;
  } out_t;

  typedef struct packed {
    logic [1:0] rd_sel;
    logic       clr_we;
    logic       latch_in;
    logic       upd;
    logic       flush_start;
    logic       sweep;
    logic       load_flush;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic in_is_flush;
    logic sweep_last;
    logic sweep_more;
    logic out_free;
  } stat_t;

endpackage

[hw/rtl/salc_ctrl.sv]
// Controller of the LRU cache model: clearing pass, access and flush sequencing.
// Depends on salc_pkg.
`timescale 1ns / 1ps
module salc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  salc_pkg::stat_t stat,
  output salc_pkg::cmd_t  cmd,
  output logic          clearing
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_ACC   = 3'd2;
  localparam logic [2:0] ST_FLUSH = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_FDONE = 3'd5;

  logic [2:0] state, state_next;
  logic       accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign clearing = (state == ST_CLEAR);

  always_comb begin
    state_next      = state;
    cmd             = '0;
    cmd.rd_sel      = salc_pkg::RD_IN;
    case (state)
      ST_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (stat.clr_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          cmd.latch_in = 1'b1;
          if (stat.in_is_flush) begin
            cmd.flush_start = 1'b1;
            state_next      = ST_FLUSH;
          end else begin
            state_next = ST_ACC;
          end
        end
      end
      ST_ACC: begin
        cmd.rd_sel = salc_pkg::RD_HOLD;
        if (stat.out_free) begin
          cmd.upd    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        cmd.rd_sel = salc_pkg::RD_SWEEP;
        cmd.sweep  = 1'b1;
        if (stat.sweep_last && !stat.sweep_more) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_next = ST_FDONE;
      end
      ST_FDONE: begin
        if (stat.out_free) begin
          cmd.load_flush = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

[hw/rtl/salc_dp.sv]
// Datapath of the LRU cache model: config registers, line memories, LRU update,
// flush accumulator and output register. Depends on salc_pkg.
`timescale 1ns / 1ps
module salc_dp #(
  parameter int MAX_SETS = 1024,
  parameter int MAX_WAYS = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  salc_pkg::in_t   in_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [3:0]      cfg_index,
  input  logic [3:0]      cfg_data,
  output logic            out_valid,
  input  logic            out_ready,
  output salc_pkg::out_t  out_data,
  input  salc_pkg::cmd_t  cmd,
  output salc_pkg::stat_t stat
);

  localparam int SET_W  = $clog2(MAX_SETS + 1) - 1;
  localparam int SET_IW = (SET_W > 0) ? SET_W : 1;
  localparam int ROW_W  = SET_IW + 1;
  localparam int ROWS   = 1 << ROW_W;
  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int TW     = salc_pkg::TAG_W;

  // configuration
  logic       split_mode, write_back, write_allocate;
  logic [3:0] unified_set_bits, inst_set_bits, data_set_bits, ways;
  logic [2:0] block_offset_bits;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      split_mode        <= 1'b0;
      unified_set_bits  <= 4'd9;
      inst_set_bits     <= 4'd9;
      data_set_bits     <= 4'd9;
      block_offset_bits <= 3'd4;
      ways              <= 4'd1;
      write_back        <= 1'b1;
      write_allocate    <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        salc_pkg::REG_SPLIT_MODE:     split_mode        <= cfg_data[0];
        salc_pkg::REG_UNIFIED_SETS:   unified_set_bits  <= cfg_data;
        salc_pkg::REG_INST_SETS:      inst_set_bits     <= cfg_data;
        salc_pkg::REG_DATA_SETS:      data_set_bits     <= cfg_data;
        salc_pkg::REG_BLOCK_OFFSET:   block_offset_bits <= cfg_data[2:0];
        salc_pkg::REG_WAYS:           ways              <= cfg_data;
        salc_pkg::REG_WRITE_BACK:     write_back        <= cfg_data[0];
        salc_pkg::REG_WRITE_ALLOCATE: write_allocate    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  function automatic logic [4:0] clamp_sb(input logic [3:0] v);
    logic [4:0] e;
    e = {1'b0, v};
    return (e > 5'(SET_W)) ? 5'(SET_W) : e;
  endfunction

  logic [2:0]          ob;
  logic [2:0]          wsh;
  logic [5:0]          bw;
  logic [4:0]          nw;
  logic [MAX_WAYS-1:0] act;

  assign ob  = (block_offset_bits < 3'd2) ? 3'd2 : block_offset_bits;
  assign wsh = ob - 3'd2;
  assign bw  = 6'd1 << wsh;

  always_comb begin
    nw = {1'b0, ways};
    if (ways == 4'd0) nw = 5'd1;
    else if (nw > 5'(MAX_WAYS)) nw = 5'(MAX_WAYS);
    for (int w = 0; w < MAX_WAYS; w++) act[w] = (5'(w) < nw);
  end

  // address split of the incoming item
  logic            in_bank;
  logic [4:0]      in_sb;
  logic [31:0]     in_shift, in_set_full;
  logic [5:0]      tag_sh;
  logic [31:0]     in_tag_full;
  logic [ROW_W-1:0] in_row;

  assign in_bank     = split_mode && (in_data.mode == salc_pkg::MODE_FETCH);
  assign in_sb       = clamp_sb(split_mode ? (in_bank ? inst_set_bits : data_set_bits)
                                           : unified_set_bits);
  assign in_shift    = in_data.address >> ob;
  assign in_set_full = in_shift & ((32'd1 << in_sb) - 32'd1);
  assign tag_sh      = 6'(ob) + 6'(in_sb);
  assign in_tag_full = in_data.address >> tag_sh;
  assign in_row      = {in_bank, in_set_full[SET_IW-1:0]};

  logic [1:0]       mode_q;
  logic [ROW_W-1:0] row_q;
  logic [TW-1:0]    tag_q;

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      mode_q <= in_data.mode;
      row_q  <= in_row;
      tag_q  <= in_tag_full[TW-1:0];
    end
  end

  // flush sweep position
  logic              sw_bank;
  logic [SET_IW-1:0] sw_cnt;
  logic [4:0]        sw_sb;
  logic [16:0]       sw_lim;

  assign sw_sb  = clamp_sb(split_mode ? (sw_bank ? inst_set_bits : data_set_bits)
                                      : unified_set_bits);
  assign sw_lim = (17'd1 << sw_sb) - 17'd1;
  assign stat.sweep_last = (sw_cnt == sw_lim[SET_IW-1:0]);
  assign stat.sweep_more = split_mode && sw_bank;

  always_ff @(posedge clk) begin
    if (cmd.flush_start) begin
      sw_bank <= split_mode;
      sw_cnt  <= '0;
    end else if (cmd.sweep) begin
      if (stat.sweep_last) begin
        sw_bank <= 1'b0;
        sw_cnt  <= '0;
      end else begin
        sw_cnt <= sw_cnt + 1'b1;
      end
    end
  end

  // clearing pass counter
  logic [ROW_W-1:0] clr_cnt;
  assign stat.clr_done = (clr_cnt == '1);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_we) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // line memories, one row per (bank, set)
  logic [MAX_WAYS-1:0]    valid_mem [ROWS];
  logic [MAX_WAYS-1:0]    dirty_mem [ROWS];
  logic [MAX_WAYS*3-1:0]  age_mem   [ROWS];
  logic [MAX_WAYS*TW-1:0] tag_mem   [ROWS];

  logic [ROW_W-1:0]       rd_row, wr_row;
  logic [MAX_WAYS-1:0]    rd_valid, rd_dirty;
  logic [MAX_WAYS*3-1:0]  rd_age;
  logic [MAX_WAYS*TW-1:0] rd_tag;
  logic [MAX_WAYS-1:0]    nx_valid, nx_dirty;
  logic [MAX_WAYS*3-1:0]  nx_age;
  logic [MAX_WAYS*TW-1:0] nx_tag;

  always_comb begin
    case (cmd.rd_sel)
      salc_pkg::RD_HOLD:  rd_row = row_q;
      salc_pkg::RD_SWEEP: rd_row = {sw_bank, sw_cnt};
      default:            rd_row = in_row;
    endcase
  end

  assign wr_row = cmd.clr_we ? clr_cnt : row_q;

  always_ff @(posedge clk) begin
    rd_valid <= valid_mem[rd_row];
    rd_dirty <= dirty_mem[rd_row];
    rd_age   <= age_mem[rd_row];
    rd_tag   <= tag_mem[rd_row];
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_we || cmd.upd) begin
      valid_mem[wr_row] <= cmd.clr_we ? '0 : nx_valid;
      dirty_mem[wr_row] <= cmd.clr_we ? '0 : nx_dirty;
      age_mem[wr_row]   <= cmd.clr_we ? '0 : nx_age;
    end
    if (cmd.upd) begin
      tag_mem[wr_row] <= nx_tag;
    end
  end

  // lookup, victim choice and LRU update
  logic             is_store, any_hit, any_inv, do_touch, t_valid, replaced;
  logic [WAY_W-1:0] hit_way, inv_way, old_way, t_way;
  logic [2:0]       best;
  logic [3:0]       old_age;
  logic [5:0]       cb, fetch;

  always_comb begin
    is_store = (mode_q == salc_pkg::MODE_STORE);
    any_hit  = 1'b0;
    hit_way  = '0;
    any_inv  = 1'b0;
    inv_way  = '0;
    old_way  = '0;
    best     = 3'd0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (!any_hit && act[w] && rd_valid[w] && rd_tag[w*TW +: TW] == tag_q) begin
        any_hit = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!any_inv && act[w] && !rd_valid[w]) begin
        any_inv = 1'b1;
        inv_way = WAY_W'(w);
      end
      if (act[w] && rd_age[w*3 +: 3] > best) begin
        best    = rd_age[w*3 +: 3];
        old_way = WAY_W'(w);
      end
    end

    nx_valid = rd_valid;
    nx_dirty = rd_dirty;
    nx_age   = rd_age;
    nx_tag   = rd_tag;
    replaced = 1'b0;
    fetch    = 6'd0;
    cb       = 6'd0;
    do_touch = 1'b0;
    t_way    = hit_way;
    t_valid  = 1'b1;

    if (any_hit) begin
      do_touch = 1'b1;
      if (is_store) begin
        nx_dirty[hit_way] = write_back;
        cb                = {5'd0, !write_back};
      end
    end else if (is_store && !write_allocate) begin
      cb = 6'd1;
    end else begin
      do_touch = 1'b1;
      t_way    = any_inv ? inv_way : old_way;
      t_valid  = rd_valid[t_way];
      replaced = t_valid;
      if (t_valid && rd_dirty[t_way]) cb = bw;
      cb       = cb + {5'd0, is_store && !write_back};
      fetch    = bw;
      nx_valid[t_way] = 1'b1;
      nx_dirty[t_way] = is_store && write_back;
      nx_tag[t_way*TW +: TW] = tag_q;
    end

    old_age = t_valid ? {1'b0, rd_age[t_way*3 +: 3]} : 4'd8;
    if (do_touch) begin
      for (int i = 0; i < MAX_WAYS; i++) begin
        if (act[i] && WAY_W'(i) != t_way && rd_valid[i] &&
            {1'b0, rd_age[i*3 +: 3]} < old_age && rd_age[i*3 +: 3] < 3'd7) begin
          nx_age[i*3 +: 3] = rd_age[i*3 +: 3] + 3'd1;
        end
      end
      nx_age[t_way*3 +: 3] = 3'd0;
    end
  end

  // flush accumulation, one row behind the sweep address
  logic        pend;
  logic [19:0] fl_sum;
  logic [4:0]  dcnt;

  always_comb begin
    dcnt = 5'd0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      dcnt = dcnt + {4'd0, act[w] && rd_valid[w] && rd_dirty[w]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= cmd.sweep;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.flush_start) begin
      fl_sum <= '0;
    end else if (pend) begin
      fl_sum <= fl_sum + (20'(dcnt) << wsh);
    end
  end

  // output register
  assign stat.out_free    = !out_valid || out_ready;
  assign stat.in_is_flush = (in_data.mode == salc_pkg::MODE_FLUSH);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.upd || cmd.load_flush) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      out_data.hit            <= any_hit;
      out_data.missed         <= !any_hit;
      out_data.replaced       <= replaced;
      out_data.fetch_words    <= fetch;
      out_data.copyback_words <= cb;
      out_data.flush_words    <= '0;
    end else if (cmd.load_flush) begin
      out_data <= '{hit: 1'b0, missed: 1'b0, replaced: 1'b0, fetch_words: 6'd0,
                    copyback_words: 6'd0, flush_words: fl_sum};
    end
  end

endmodule

[hw/rtl/set_assoc_lru_cache_model.sv]
// Set-associative LRU cache model.
// Channels: in (mode, address), out (hit/miss/replace and word counts), cfg
// (register index and 4-bit data), all valid/ready; a transfer happens when
// valid and ready are both high.
// Load, store and fetch: one read of the set row in the line memories, then
// the LRU/tag/dirty update and the write of that row.
// Flush: the active sets of each active bank are swept, one set row a cycle.
// One item is worked at a time; a finished result sits in the output register
// so the next item is taken while it waits. If the receiver stalls, an access
// or flush that is done holds until the output register frees up.
// Reset: config returns to defaults, then a clearing pass zeroes the valid,
// dirty and age rows; no input is taken during it, config writes are.
// cfg_ready is always high.
// Depends on salc_pkg, salc_ctrl, salc_dp and the assertion macro header.
`timescale 1ns / 1ps
`include "set_assoc_lru_cache_model_assert.svh"
module set_assoc_lru_cache_model #(
  parameter int MAX_SETS = 1024,
  parameter int MAX_WAYS = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  salc_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output salc_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [3:0]     cfg_index,
  input  logic [3:0]     cfg_data
);

  salc_pkg::cmd_t  cmd;
  salc_pkg::stat_t stat;
  logic            clearing;

  salc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd),
    .clearing (clearing)
  );

  salc_dp #(
    .MAX_SETS (MAX_SETS),
    .MAX_WAYS (MAX_WAYS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

  `SALC_ASSERT_IMPL(a_no_take_clearing, clearing, !in_ready)
  `SALC_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)
  `SALC_ASSERT_IMPL(a_hit_xor_miss, out_valid, !(out_data.hit && out_data.missed))
  `SALC_ASSERT_IMPL(a_replace_on_miss, out_valid && out_data.replaced,
                    out_data.missed && out_data.fetch_words != 6'd0)

endmodule

[tb/salc_result_checker.sv]
// Result checker for the LRU cache model: watches the config, request and
// result channels, predicts each result and compares it field by field.
// Depends on salc_pkg.
`timescale 1ns / 1ps
module salc_result_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_ready,
  input  salc_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_ready,
  input  salc_pkg::out_t out_data,
  input  logic           cfg_valid,
  input  logic           cfg_ready,
  input  logic [3:0]     cfg_index,
  input  logic [3:0]     cfg_data,
  output int             fail_count,
  output int             pending
);
  import salc_pkg::*;

  localparam int SETS = 1024;
  localparam int NWAYS = 8;
  localparam int LINES = 2 * SETS * NWAYS;

  bit        ln_valid [LINES];
  bit [31:0] ln_tag   [LINES];
  bit        ln_dirty [LINES];
  bit [2:0]  ln_age   [LINES];

  bit       split;
  bit [3:0] uni_bits, inst_bits, data_bits, way_cfg;
  bit [2:0] offset_cfg;
  bit       wr_back, wr_alloc;

  out_t expected_results[$];

  function automatic int set_bits_of(bit [3:0] sb);
    return (sb > 10) ? 10 : int'(sb);
  endfunction

  function automatic int offset_of();
    return (offset_cfg < 2) ? 2 : int'(offset_cfg);
  endfunction

  function automatic int block_words();
    return 1 << (offset_of() - 2);
  endfunction

  function automatic int active_ways();
    if (way_cfg == 0) return 1;
    return (way_cfg > NWAYS) ? NWAYS : int'(way_cfg);
  endfunction

  // promote way w to most recent; younger lines age by one, capped at 7
  function automatic void make_recent(int base, int w, int nw, bit was_valid);
    int old;
    old = was_valid ? int'(ln_age[base + w]) : 8;
    for (int i = 0; i < nw; i++) begin
      if (i != w && ln_valid[base + i] && ln_age[base + i] < old && ln_age[base + i] < 7)
        ln_age[base + i]++;
    end
    ln_age[base + w] = 0;
  endfunction

  function automatic int dirty_words(int bank, int sb);
    int sum, k;
    sum = 0;
    for (int s = 0; s < (1 << sb); s++) begin
      for (int w = 0; w < active_ways(); w++) begin
        k = (bank * SETS + s) * NWAYS + w;
        if (ln_valid[k] && ln_dirty[k]) sum += block_words();
      end
    end
    return sum;
  endfunction

  function automatic out_t access_cache(in_t req);
    out_t r;
    int bank, sb, ob, set_idx, base, nw, found, victim, best, cb;
    bit [31:0] tag;
    bit is_store, was_valid;
    r = '0;
    cb = 0;
    if (req.mode == MODE_FLUSH) begin
      if (split)
        r.flush_words = 20'(dirty_words(1, set_bits_of(inst_bits)) +
                            dirty_words(0, set_bits_of(data_bits)));
      else
        r.flush_words = 20'(dirty_words(0, set_bits_of(uni_bits)));
      return r;
    end
    bank = (split && req.mode == MODE_FETCH) ? 1 : 0;
    sb = set_bits_of(split ? (bank ? inst_bits : data_bits) : uni_bits);
    ob = offset_of();
    set_idx = int'((req.address >> ob) & ((32'd1 << sb) - 1));
    tag = req.address >> (ob + sb);
    base = (bank * SETS + set_idx) * NWAYS;
    nw = active_ways();
    found = nw;
    is_store = (req.mode == MODE_STORE);
    for (int w = 0; w < nw; w++) begin
      if (ln_valid[base + w] && ln_tag[base + w] == tag) begin
        found = w;
        break;
      end
    end
    if (found < nw) begin
      r.hit = 1;
      make_recent(base, found, nw, 1);
      if (is_store) begin
        if (wr_back) ln_dirty[base + found] = 1;
        else begin
          ln_dirty[base + found] = 0;
          cb = 1;
        end
      end
    end else begin
      r.missed = 1;
      if (is_store && !wr_alloc) cb = 1;
      else begin
        victim = nw;
        for (int w = 0; w < nw; w++) begin
          if (!ln_valid[base + w]) begin
            victim = w;
            break;
          end
        end
        if (victim == nw) begin
          victim = 0;
          best = 0;
          for (int w = 0; w < nw; w++) begin
            if (ln_age[base + w] > best) begin
              best = ln_age[base + w];
              victim = w;
            end
          end
        end
        was_valid = ln_valid[base + victim];
        if (was_valid) begin
          r.replaced = 1;
          if (ln_dirty[base + victim]) cb += block_words();
        end
        r.fetch_words = 6'(block_words());
        make_recent(base, victim, nw, was_valid);
        ln_valid[base + victim] = 1;
        ln_tag[base + victim] = tag;
        ln_dirty[base + victim] = 0;
        if (is_store) begin
          if (wr_back) ln_dirty[base + victim] = 1;
          else cb += 1;
        end
      end
    end
    r.copyback_words = 6'(cb);
    return r;
  endfunction

  function automatic void check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    out_t exp_r;
    if (rst) begin
      for (int i = 0; i < LINES; i++) begin
        ln_valid[i] = 0;
        ln_tag[i] = 0;
        ln_dirty[i] = 0;
        ln_age[i] = 0;
      end
      split = 0; uni_bits = 9; inst_bits = 9; data_bits = 9;
      offset_cfg = 4; way_cfg = 1; wr_back = 1; wr_alloc = 1;
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SPLIT_MODE:     split = cfg_data[0];
          REG_UNIFIED_SETS:   uni_bits = cfg_data;
          REG_INST_SETS:      inst_bits = cfg_data;
          REG_DATA_SETS:      data_bits = cfg_data;
          REG_BLOCK_OFFSET:   offset_cfg = cfg_data[2:0];
          REG_WAYS:           way_cfg = cfg_data;
          REG_WRITE_BACK:     wr_back = cfg_data[0];
          REG_WRITE_ALLOCATE: wr_alloc = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_results.push_back(access_cache(in_data));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no request outstanding");
          fail_count++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("hit", exp_r.hit, out_data.hit);
          check_field("missed", exp_r.missed, out_data.missed);
          check_field("replaced", exp_r.replaced, out_data.replaced);
          check_field("fetch_words", exp_r.fetch_words, out_data.fetch_words);
          check_field("copyback_words", exp_r.copyback_words, out_data.copyback_words);
          check_field("flush_words", exp_r.flush_words, out_data.flush_words);
        end
      end
    end
    pending = expected_results.size();
  end
endmodule

[tb/tb_set_assoc_lru_cache_model.sv]
// Top of the LRU cache model testbench: clock, reset, config phases and
// access traces; verdict from the result checker's failure count.
// Depends on salc_pkg, salc_result_checker and set_assoc_lru_cache_model.
`timescale 1ns / 1ps
module tb_set_assoc_lru_cache_model;
  import salc_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_t        in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_t       out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [3:0] cfg_index = '0;
  logic [3:0] cfg_data = '0;
  int         fail_count, pending;
  int         send_idle = 0, recv_idle = 0;
  bit [31:0]  addr_pool[12];

  always #5 clk = ~clk;

  set_assoc_lru_cache_model i_dut (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  salc_result_checker i_checker (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .fail_count,
    .pending
  );

  always @(posedge clk) out_ready <= rst ? 1'b0 : ($urandom_range(99) >= recv_idle);

  task automatic send_access(logic [1:0] mode, logic [31:0] addr);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{mode: mode, address: addr};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_config(bit sp, bit [3:0] ub, bit [3:0] ib, bit [3:0] db,
                             bit [3:0] ob, bit [3:0] nw, bit wb, bit wa);
    logic [3:0] vals[8];
    vals = '{4'(sp), ub, ib, db, ob, nw, 4'(wb), 4'(wa)};
    for (int r = 0; r < 8; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 4'(r);
      cfg_data <= vals[r];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic random_trace(int count);
    int pick;
    logic [1:0] mode;
    logic [31:0] addr;
    bit [31:0] shared_low;
    shared_low = $urandom;
    // half the pool aliases to one set under any geometry, forcing evictions
    for (int k = 0; k < 12; k++)
      addr_pool[k] = (k < 6) ? {15'($urandom), shared_low[16:0]} : $urandom;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 3) mode = MODE_FLUSH;
      else if (pick < 36) mode = MODE_LOAD;
      else if (pick < 70) mode = MODE_STORE;
      else mode = MODE_FETCH;
      if ($urandom_range(99) < 15) addr = $urandom;
      else addr = addr_pool[$urandom_range(11)] ^ ($urandom & 32'h7f);
      send_access(mode, addr);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    load_config(0, 9, 9, 9, 4, 1, 1, 1);
    // directed: field extremes, dirty eviction, write-through, no-allocate
    send_access(MODE_LOAD, 32'h0);
    send_access(MODE_STORE, 32'h0);
    send_access(MODE_LOAD, 32'hffff_ffff);
    send_access(MODE_FETCH, 32'hffff_ffff);
    send_access(MODE_FLUSH, 32'h0);
    send_access(MODE_STORE, 32'h2000);
    send_access(MODE_LOAD, 32'h0);
    send_access(MODE_FLUSH, 32'hffff_ffff);
    drain();
    load_config(1, 0, 10, 2, 7, 8, 0, 0);
    send_access(MODE_STORE, 32'h100);
    send_access(MODE_LOAD, 32'h100);
    send_access(MODE_STORE, 32'h100);
    send_access(MODE_FETCH, 32'h100);
    send_access(MODE_FLUSH, 32'h0);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      send_idle = (ph < 2) ? 10 : (ph < 4) ? 79 : 0;
      recv_idle = (ph < 2) ? 79 : (ph < 4) ? 10 : 0;
      case (ph)
        0: load_config(0, 9, 9, 9, 4, 1, 1, 1);
        1: load_config(1, 0, 10, 2, 7, 8, 0, 0);
        2: load_config(1, 15, 3, 11, 2, 4, 1, 0);
        3: load_config(0, 2, 0, 0, 0, 0, 0, 1);
        4: load_config(0, 10, 5, 5, 1, 15, 1, 1);
        default: load_config(1, 1, 1, 1, 5, 3, 0, 1);
      endcase
      random_trace(150);
      drain();
    end
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end
endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/salc_pkg.sv
hw/rtl/salc_ctrl.sv
hw/rtl/salc_dp.sv
hw/rtl/set_assoc_lru_cache_model.sv
tb/salc_result_checker.sv
tb/tb_set_assoc_lru_cache_model.sv
